/* design/ws_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the WS2812 pixel serializer.
// Used by the request channel interface and every module of the design.
package ws_pkg;

	localparam int BITS_PER_PIXEL = 24;
	localparam int COLOR_W = 24;
	localparam int CYCLE_W = 8;
	localparam int FRAME_W = 10;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 10;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CYCLE_W-1:0] ZERO_HIGH_RST = 8'd6;
	localparam logic [CYCLE_W-1:0] ONE_HIGH_RST = 8'd13;
	localparam logic [CYCLE_W-1:0] PERIOD_RST = 8'd20;
	localparam logic [FRAME_W-1:0] FRAME_PIX_RST = 10'd12;

	localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_PIX = 2'd3;

	typedef enum logic {
		CMD_TICK = 1'b0,
		CMD_LOAD = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic [COLOR_W-1:0] color;
	} item_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic load_rejected;
		logic pixel_done;
		logic frame_done;
	} res_t;

	typedef struct packed {
		logic we;
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_DATA_W-1:0] wdata;
	} cfg_t;

endpackage

/* design/ws_in_if.sv */
`timescale 1ns / 1ps
// Request channel of the pixel serializer: tick or load items.
// Depends on ws_pkg for field widths.
interface ws_in_if;
	logic valid;
	logic ready;
	logic req_type;
	logic [ws_pkg::COLOR_W-1:0] pixel_color;

	modport source (output valid, output req_type, output pixel_color, input ready);
	modport sink (input valid, input req_type, input pixel_color, output ready);
endinterface

/* design/ws_out_if.sv */
`timescale 1ns / 1ps
// Result channel of the pixel serializer: one result item per request item.
// Has no dependencies.
interface ws_out_if;
	logic valid;
	logic ready;
	logic line_level;
	logic busy_res;
	logic load_rejected;
	logic pixel_done;
	logic frame_done;

	modport source (output valid, output line_level, output busy_res,
		output load_rejected, output pixel_done, output frame_done, input ready);
	modport sink (input valid, input line_level, input busy_res,
		input load_rejected, input pixel_done, input frame_done, output ready);
endinterface

/* design/ws_front.sv */
`timescale 1ns / 1ps
// Front stage: accepts request items and decodes them into commands.
// Depends on ws_pkg and ws_in_if.
module ws_front (
	input logic clk,
	input logic arst_n,
	ws_in_if.sink req,
	output logic push_valid,
	output ws_pkg::item_t push_item,
	input logic push_ready
);

	logic valid_s1;
	ws_pkg::item_t item_s1;
	logic take;

	assign req.ready = !valid_s1 || push_ready;
	assign take = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.cmd <= req.req_type ? ws_pkg::CMD_LOAD : ws_pkg::CMD_TICK;
			item_s1.color <= req.pixel_color;
		end
	end

	assign push_valid = valid_s1;
	assign push_item = item_s1;

endmodule

/* design/ws_queue.sv */
`timescale 1ns / 1ps
// Short command queue between the front stage and the waveform engine.
// Depends on ws_pkg for the item type.
module ws_queue #(
	parameter int DEPTH = ws_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	input ws_pkg::item_t push_item,
	output logic push_ready,
	output logic pop_valid,
	output ws_pkg::item_t pop_item,
	input logic pop_ready
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ws_pkg::item_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic push;
	logic pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid = count_q != '0;
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* design/ws_back.sv */
`timescale 1ns / 1ps
// Waveform engine: holds the timing registers and pixel state, executes one
// command per cycle unless the result output stalls, and registers its result item. Depends on ws_pkg.
module ws_back #(
	parameter int BITS_PER_PIXEL = ws_pkg::BITS_PER_PIXEL
) (
	input logic clk,
	input logic arst_n,
	input ws_pkg::cfg_t cfg,
	input logic pop_valid,
	input ws_pkg::item_t pop_item,
	output logic pop_ready,
	ws_out_if.source res
);

	localparam int IDX_W = $clog2(BITS_PER_PIXEL);
	localparam int CW = ws_pkg::CYCLE_W;
	localparam int FW = ws_pkg::FRAME_W;

	logic [CW-1:0] zero_high_q;
	logic [CW-1:0] one_high_q;
	logic [CW-1:0] period_q;
	logic [FW-1:0] frame_pix_q;

	logic [BITS_PER_PIXEL-1:0] shift_q, shift_d;
	logic [IDX_W-1:0] bit_idx_q, bit_idx_d;
	logic [CW-1:0] cycle_q, cycle_d;
	logic sending_q, sending_d;
	logic [FW-1:0] pix_cnt_q, pix_cnt_d;

	logic out_valid_q;
	ws_pkg::res_t res_q;
	ws_pkg::res_t res_d;

	logic pop;
	logic [CW-1:0] high;
	logic [FW-1:0] pix_inc;

	assign pop_ready = !out_valid_q || res.ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_high_q <= ws_pkg::ZERO_HIGH_RST;
			one_high_q <= ws_pkg::ONE_HIGH_RST;
			period_q <= ws_pkg::PERIOD_RST;
			frame_pix_q <= ws_pkg::FRAME_PIX_RST;
		end else if (cfg.we) begin
			case (cfg.index)
				ws_pkg::REG_ZERO_HIGH: zero_high_q <= cfg.wdata[CW-1:0];
				ws_pkg::REG_ONE_HIGH: one_high_q <= cfg.wdata[CW-1:0];
				ws_pkg::REG_PERIOD: period_q <= cfg.wdata[CW-1:0];
				ws_pkg::REG_FRAME_PIX: frame_pix_q <= cfg.wdata[FW-1:0];
				default: ;
			endcase
		end
	end

	assign high = shift_q[BITS_PER_PIXEL-1] ? one_high_q : zero_high_q;
	assign pix_inc = pix_cnt_q + 1'b1;

	always_comb begin
		shift_d = shift_q;
		bit_idx_d = bit_idx_q;
		cycle_d = cycle_q;
		sending_d = sending_q;
		pix_cnt_d = pix_cnt_q;
		res_d = '0;
		if (pop_item.cmd == ws_pkg::CMD_LOAD) begin
			res_d.busy_res = 1'b1;
			if (sending_q) begin
				res_d.load_rejected = 1'b1;
			end else begin
				shift_d = BITS_PER_PIXEL'(pop_item.color);
				bit_idx_d = '0;
				cycle_d = '0;
				sending_d = 1'b1;
			end
		end else if (sending_q) begin
			res_d.busy_res = 1'b1;
			res_d.line_level = cycle_q < high;
			if ({1'b0, cycle_q} + 9'd1 >= {1'b0, period_q}) begin
				cycle_d = '0;
				shift_d = shift_q << 1;
				if (bit_idx_q == IDX_W'(BITS_PER_PIXEL - 1)) begin
					bit_idx_d = '0;
					sending_d = 1'b0;
					res_d.pixel_done = 1'b1;
					if (pix_inc >= frame_pix_q || pix_inc == '0) begin
						res_d.frame_done = 1'b1;
						pix_cnt_d = '0;
					end else begin
						pix_cnt_d = pix_inc;
					end
				end else begin
					bit_idx_d = bit_idx_q + 1'b1;
				end
			end else begin
				cycle_d = cycle_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
			bit_idx_q <= '0;
			cycle_q <= '0;
			sending_q <= 1'b0;
			pix_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				shift_q <= shift_d;
				bit_idx_q <= bit_idx_d;
				cycle_q <= cycle_d;
				sending_q <= sending_d;
				pix_cnt_q <= pix_cnt_d;
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
		end
	end

	assign res.valid = out_valid_q;
	assign res.line_level = res_q.line_level;
	assign res.busy_res = res_q.busy_res;
	assign res.load_rejected = res_q.load_rejected;
	assign res.pixel_done = res_q.pixel_done;
	assign res.frame_done = res_q.frame_done;

endmodule

/* design/ws2812_pixel_serializer.sv */
`timescale 1ns / 1ps
// Channel    | Role | Payload
// pixel      | sink | req_type, pixel_color
// result     | src  | line_level, busy_res, load_rejected, pixel_done, frame_done
// One item per clock is accepted and one result per clock delivered, sustained while the result side is not stalled.
// An accepted item passes the front register, then the queue, and its result
// is held in the engine's output register.
// The engine executes one command per cycle while the result side is not stalled;
// the two-entry queue lets the front keep accepting until it fills while the result side stalls.
// Reset clears all pixel state and loads the timing registers' defaults.
// Top level of the WS2812 pixel serializer; depends on ws_pkg, the channel
// interfaces, ws_front, ws_queue and ws_back.
module ws2812_pixel_serializer #(
	parameter int BITS_PER_PIXEL = ws_pkg::BITS_PER_PIXEL
) (
	input logic clk,
	input logic arst_n,
	ws_in_if.sink pixel,
	ws_out_if.source result,
	input logic cfg_we,
	input logic [ws_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [ws_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	logic push_valid;
	logic push_ready;
	ws_pkg::item_t push_item;
	logic pop_valid;
	logic pop_ready;
	ws_pkg::item_t pop_item;
	ws_pkg::cfg_t cfg;

	assign cfg.we = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.wdata = cfg_wdata;

	ws_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req(pixel),
		.push_valid(push_valid),
		.push_item(push_item),
		.push_ready(push_ready)
	);

	ws_queue #(
		.DEPTH(ws_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_item(push_item),
		.push_ready(push_ready),
		.pop_valid(pop_valid),
		.pop_item(pop_item),
		.pop_ready(pop_ready)
	);

	ws_back #(
		.BITS_PER_PIXEL(BITS_PER_PIXEL)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.pop_valid(pop_valid),
		.pop_item(pop_item),
		.pop_ready(pop_ready),
		.res(result)
	);

`ifndef SYNTHESIS
	a_frame_needs_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.frame_done |-> result.pixel_done)
		else $error("frame end without pixel end");

	a_reject_is_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.load_rejected || result.line_level) |-> result.busy_res)
		else $error("line or reject flag while idle");

	a_reject_no_level: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.load_rejected |-> !result.line_level && !result.pixel_done)
		else $error("rejected load drove the line");
`endif

endmodule

/* tb/ws_line_checker.sv */
`timescale 1ns / 1ps
// Checker for the WS2812 pixel serializer: watches the request, result and register ports,
// predicts each result item and compares it field by field with what the block returns.
// Depends on ws_pkg and the ws_in_if / ws_out_if channel interfaces.
module ws_line_checker (
	input logic clk,
	input logic arst_n,
	ws_in_if pix,
	ws_out_if res,
	input logic cfg_we,
	input logic [ws_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [ws_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int errors,
	output int outstanding
);
	import ws_pkg::*;

	logic [CYCLE_W-1:0] zero_len, one_len, period_len;
	logic [FRAME_W-1:0] frame_len;

	logic [BITS_PER_PIXEL-1:0] pix_word;
	logic [4:0] bit_pos;
	logic [CYCLE_W-1:0] clk_in_bit;
	logic shifting;
	logic [FRAME_W-1:0] frame_pix;

	res_t line_expect_q[$];
	res_t got, want;
	int fail_tally;

	function automatic res_t advance_line(cmd_t cmd, logic [COLOR_W-1:0] color);
		res_t r;
		logic [CYCLE_W-1:0] high_len;
		logic [FRAME_W-1:0] next_count;
		r = '0;
		if (cmd == CMD_LOAD) begin
			if (shifting) begin
				r.load_rejected = 1'b1;
			end else begin
				pix_word = color[BITS_PER_PIXEL-1:0];
				bit_pos = '0;
				clk_in_bit = '0;
				shifting = 1'b1;
			end
			r.busy_res = 1'b1;
		end else if (shifting) begin
			high_len = pix_word[BITS_PER_PIXEL-1] ? one_len : zero_len;
			r.busy_res = 1'b1;
			r.line_level = (clk_in_bit < high_len);
			if (int'(clk_in_bit) + 1 >= int'(period_len)) begin
				clk_in_bit = '0;
				pix_word = pix_word << 1;
				if (int'(bit_pos) + 1 >= BITS_PER_PIXEL) begin
					bit_pos = '0;
					shifting = 1'b0;
					r.pixel_done = 1'b1;
					next_count = frame_pix + 1'b1;
					// A zero count, or one lowered below the pixels sent, ends the frame here.
					if (next_count >= frame_len || next_count == '0) begin
						r.frame_done = 1'b1;
						frame_pix = '0;
					end else begin
						frame_pix = next_count;
					end
				end else begin
					bit_pos = bit_pos + 1'b1;
				end
			end else begin
				clk_in_bit = clk_in_bit + 1'b1;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_len = ZERO_HIGH_RST;
			one_len = ONE_HIGH_RST;
			period_len = PERIOD_RST;
			frame_len = FRAME_PIX_RST;
			pix_word = '0;
			bit_pos = '0;
			clk_in_bit = '0;
			shifting = 1'b0;
			frame_pix = '0;
			line_expect_q.delete();
			fail_tally = 0;
			errors <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ZERO_HIGH: zero_len = cfg_wdata[CYCLE_W-1:0];
					REG_ONE_HIGH: one_len = cfg_wdata[CYCLE_W-1:0];
					REG_PERIOD: period_len = cfg_wdata[CYCLE_W-1:0];
					REG_FRAME_PIX: frame_len = cfg_wdata[FRAME_W-1:0];
					default: ;
				endcase
			end
			if (res.valid && res.ready) begin
				got.line_level = res.line_level;
				got.busy_res = res.busy_res;
				got.load_rejected = res.load_rejected;
				got.pixel_done = res.pixel_done;
				got.frame_done = res.frame_done;
				if (line_expect_q.size() == 0) begin
					if (fail_tally < 10)
						$display("[%0t] unexpected result item: level=%b busy=%b rej=%b pdone=%b fdone=%b",
							$realtime, got.line_level, got.busy_res, got.load_rejected,
							got.pixel_done, got.frame_done);
					fail_tally++;
				end else begin
					want = line_expect_q.pop_front();
					if (got !== want) begin
						if (fail_tally < 10)
							$display("[%0t] result mismatch: expected level=%b busy=%b rej=%b pdone=%b fdone=%b, got level=%b busy=%b rej=%b pdone=%b fdone=%b",
								$realtime, want.line_level, want.busy_res, want.load_rejected,
								want.pixel_done, want.frame_done, got.line_level, got.busy_res,
								got.load_rejected, got.pixel_done, got.frame_done);
						fail_tally++;
					end
				end
			end
			if (pix.valid && pix.ready)
				line_expect_q.push_back(advance_line(cmd_t'(pix.req_type), pix.pixel_color));
			errors <= fail_tally;
			outstanding <= line_expect_q.size();
		end
	end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Testbench top for the WS2812 pixel serializer: clock, reset, stimulus and verdict.
// Depends on ws_pkg, the channel interfaces, the serializer and ws_line_checker.
module tb;
	import ws_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int fail_total;
	int in_flight;
	bit src_gaps;
	bit sink_gaps;

	ws_in_if pixel();
	ws_out_if result();

	ws2812_pixel_serializer dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel(pixel),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	ws_line_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pixel),
		.res(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.errors(fail_total),
		.outstanding(in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin : result_sink
		int stall;
		forever begin
			stall = sink_gaps ? $urandom_range(0, 7) : 0;
			if (stall != 0) begin
				result.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result.ready <= 1'b1;
			@(posedge clk);
			while (!result.valid) @(posedge clk);
		end
	end

	task automatic push_item(input cmd_t cmd, input logic [COLOR_W-1:0] color);
		int gap;
		gap = src_gaps ? $urandom_range(0, 7) : 0;
		repeat (gap) begin
			pixel.valid <= 1'b0;
			@(posedge clk);
		end
		pixel.valid <= 1'b1;
		pixel.req_type <= cmd;
		pixel.pixel_color <= color;
		@(posedge clk);
		while (!pixel.ready) @(posedge clk);
	endtask

	task automatic drain;
		pixel.valid <= 1'b0;
		@(posedge clk);
		while (in_flight != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic set_timing(input logic [CFG_DATA_W-1:0] zh, input logic [CFG_DATA_W-1:0] oh,
		input logic [CFG_DATA_W-1:0] per, input logic [CFG_DATA_W-1:0] fr);
		write_reg(REG_ZERO_HIGH, zh);
		write_reg(REG_ONE_HIGH, oh);
		write_reg(REG_PERIOD, per);
		write_reg(REG_FRAME_PIX, fr);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [COLOR_W-1:0] pick_color();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return COLOR_W'($urandom);
		endcase
	endfunction

	initial begin : stimulus
		int phase, n, ticks_left, bit_clocks, profile;
		logic [CYCLE_W-1:0] per, zh, oh;
		logic [FRAME_W-1:0] fr;

		arst_n <= 1'b0;
		pixel.valid <= 1'b0;
		pixel.req_type <= CMD_TICK;
		pixel.pixel_color <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_ZERO_HIGH;
		cfg_wdata <= '0;
		src_gaps = 1'b0;
		sink_gaps = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Idle tick, an all-ones pixel, then a load that arrives while busy.
		push_item(CMD_TICK, 24'h5A5A5A);
		push_item(CMD_LOAD, 24'hFFFFFF);
		push_item(CMD_LOAD, 24'h000000);
		drain();
		// Zero high time, full-length high time, a zero period and a zero frame count;
		// the upper data bits are set to show they are dropped for the 8-bit registers.
		set_timing(10'h200, 10'h3FF, 10'h100, 10'h000);
		repeat (24) push_item(CMD_TICK, '0);
		drain();

		ticks_left = 0;
		for (phase = 0; phase < 14; phase++) begin
			profile = $urandom_range(0, 9);
			if (phase == 3 || profile == 0) begin
				per = 8'd255;
				zh = 8'd1;
				oh = 8'd255;
				fr = 10'd1023;
			end else if (phase == 7 || profile == 1) begin
				per = 8'd2;
				zh = 8'd255;
				oh = 8'd0;
				fr = 10'd1;
			end else begin
				per = CYCLE_W'($urandom_range(0, 6));
				zh = CYCLE_W'($urandom_range(0, per + 1));
				oh = CYCLE_W'($urandom_range(0, per + 2));
				fr = FRAME_W'($urandom_range(0, 5));
			end
			set_timing({2'($urandom_range(0, 3)), zh}, {2'($urandom_range(0, 3)), oh},
				{2'($urandom_range(0, 3)), per}, fr);
			bit_clocks = (per < 2) ? 1 : int'(per);
			ticks_left = 0;
			for (n = 0; n < 100; n++) begin
				if (n % 25 == 0) begin
					src_gaps = ($urandom_range(0, 3) != 0);
					sink_gaps = ($urandom_range(0, 3) != 0);
				end
				if (ticks_left == 0) begin
					push_item(CMD_LOAD, pick_color());
					ticks_left = BITS_PER_PIXEL * bit_clocks + $urandom_range(0, 3);
					if ($urandom_range(0, 7) == 0)
						ticks_left = $urandom_range(1, ticks_left);
				end else begin
					if ($urandom_range(0, 39) == 0)
						push_item(CMD_LOAD, pick_color());
					else
						push_item(CMD_TICK, pick_color());
					ticks_left--;
				end
			end
			drain();
		end

		if (fail_total == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
